[sv/x86_integer_alu_with_flags_unit_defines.svh]
// Assertion macros for the integer ALU checker.
`ifndef X86_INTEGER_ALU_WITH_FLAGS_UNIT_DEFINES_SVH
`define X86_INTEGER_ALU_WITH_FLAGS_UNIT_DEFINES_SVH
// Check that a condition implies a consequence in the next cycle.
`define XALU_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);
// Check that a condition implies a consequence in the same cycle.
`define XALU_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);
`endif

[sv/xalu_pkg.sv]
// Shared types and constants for the integer ALU.
`default_nettype none
package xalu_pkg;
  localparam logic [3:0] OP_ADD = 4'd0, OP_SUB = 4'd1, OP_CMP = 4'd2, OP_INC = 4'd3,
    OP_DEC = 4'd4, OP_NEG = 4'd5, OP_ADC = 4'd6, OP_SBB = 4'd7, OP_MUL = 4'd8,
    OP_IMUL1 = 4'd9, OP_IMUL2 = 4'd10, OP_IMUL3 = 4'd11, OP_DIV = 4'd12,
    OP_IDIV = 4'd13;
  localparam logic [1:0] W8 = 2'd0, W16 = 2'd1;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [1:0]  op_width;
    logic [1:0]  imm_width;
    logic [31:0] dest_value;
    logic [31:0] src_value;
    logic [31:0] acc_low;
    logic [31:0] acc_high;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result;
    logic [31:0] result_high;
    logic        write_dest;
    logic        write_acc_pair;
    logic        carry_out;
    logic        overflow_out;
    logic        zero_out;
    logic        sign_out;
    logic        divide_error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_FIX, ST_DONE
  } state_t;

  // Control from sequencer to the shared datapath.
  typedef struct packed {
    logic load;
    logic mul_step;
    logic div_step;
    logic fix;
  } ctl_t;
endpackage
`default_nettype wire

[sv/xalu_datapath.sv]
// Shared shift-add multiply and restoring divide datapath, plus flag arithmetic.
`default_nettype none
module xalu_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire xalu_pkg::ctl_t    ctl,
  input  wire xalu_pkg::in_item_t item,
  output xalu_pkg::out_item_t    res,
  output logic                   is_mul,
  output logic                   is_div
);
  import xalu_pkg::*;

  function automatic logic is_mul_op(input logic [3:0] o);
    return (o == OP_MUL) || (o == OP_IMUL1) || (o == OP_IMUL2) || (o == OP_IMUL3);
  endfunction

  logic [3:0]  op;
  logic [31:0] mcand, mplier, acc_hi, acc_lo, dvsr;
  logic        negate_q, negate_r, neg_prod, derr;
  logic        cf, of, zf, sf;
  logic [31:0] rres, rhigh;
  logic        wd, wp, dflag;

  // Combinational values from the loaded item.
  logic [31:0] m, top, d, s, r, sx;
  logic [32:0] full, sub;
  logic        c_in, a_cf, a_of, arith;
  logic [31:0] da_abs, acc_abs_lo, acc_abs_hi, ld_mc, ld_mp;
  logic [63:0] n_abs;
  logic        nneg, dneg;
  logic [32:0] trial;
  logic [63:0] prod, rem_pair;

  always_comb begin
    unique case (item.op_width)
      W8:      begin m = 32'h0000_00ff; top = 32'h0000_0080; end
      W16:     begin m = 32'h0000_ffff; top = 32'h0000_8000; end
      default: begin m = 32'hffff_ffff; top = 32'h8000_0000; end
    endcase
    unique case (item.imm_width)
      W8:      sx = {{24{item.src_value[7]}}, item.src_value[7:0]};
      W16:     sx = {{16{item.src_value[15]}}, item.src_value[15:0]};
      default: sx = item.src_value;
    endcase
    d     = item.dest_value & m;
    s     = item.src_value & m;
    c_in  = ((item.opcode == OP_ADC) || (item.opcode == OP_SBB)) ? cf : 1'b0;
    full  = {1'b0, d} + {1'b0, s} + {32'd0, c_in};
    sub   = {1'b0, s} + {32'd0, c_in};
    arith = 1'b1;
    a_cf  = cf;
    a_of  = of;
    r     = '0;
    unique case (item.opcode)
      OP_ADD, OP_ADC: begin
        r = full[31:0] & m;
        unique case (item.op_width)
          W8:      a_cf = full[8];
          W16:     a_cf = full[16];
          default: a_cf = full[32];
        endcase
        a_of = |(~(d ^ s) & (d ^ r) & top);
      end
      OP_SUB, OP_CMP, OP_SBB: begin
        r    = (d - sub[31:0]) & m;
        a_cf = {1'b0, d} < sub;
        a_of = |((d ^ s) & (d ^ r) & top);
      end
      OP_INC: begin r = (d + 32'd1) & m; a_of = (r == top); end
      OP_DEC: begin r = (d - 32'd1) & m; a_of = (d == top); end
      OP_NEG: begin r = (32'd0 - d) & m; a_cf = (d != 0); a_of = (d == top); end
      default: arith = 1'b0;
    endcase
    is_mul = (item.opcode == OP_MUL) || (item.opcode == OP_IMUL1) ||
             (item.opcode == OP_IMUL2) || (item.opcode == OP_IMUL3);
    is_div = (item.opcode == OP_DIV) || (item.opcode == OP_IDIV);
    nneg   = (item.opcode == OP_IDIV) && item.acc_high[31];
    dneg   = (item.opcode == OP_IDIV) && item.dest_value[31];
    n_abs  = nneg ? (64'd0 - {item.acc_high, item.acc_low}) : {item.acc_high, item.acc_low};
    da_abs = dneg ? (32'd0 - item.dest_value) : item.dest_value;
    acc_abs_hi = n_abs[63:32];
    acc_abs_lo = n_abs[31:0];
    // imul1 magnitudes; low product is sign-independent for imul2/imul3.
    ld_mc = item.acc_low;
    ld_mp = item.dest_value;
    if (item.opcode == OP_IMUL1) begin
      ld_mc = item.acc_low[31] ? (32'd0 - item.acc_low) : item.acc_low;
      ld_mp = item.dest_value[31] ? (32'd0 - item.dest_value) : item.dest_value;
    end else if (item.opcode == OP_IMUL2) begin
      ld_mc = item.src_value;
    end else if (item.opcode == OP_IMUL3) begin
      ld_mc = sx;
    end
    trial = {acc_hi, acc_lo[31]} - {1'b0, dvsr};
    prod  = {acc_hi, acc_lo};
    rem_pair = 64'd0 - prod;
  end

  logic [32:0] madd;
  assign madd = {1'b0, acc_hi} + ((mplier[0]) ? {1'b0, mcand} : 33'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cf <= 1'b0; of <= 1'b0; zf <= 1'b0; sf <= 1'b0;
    end else if (ctl.load && arith) begin
      cf <= a_cf; of <= a_of; zf <= (r == 0); sf <= |(r & top);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op       <= item.opcode;
      rres     <= r;
      rhigh    <= '0;
      wd       <= arith ? (item.opcode != OP_CMP) : (item.opcode == OP_IMUL2 ||
                                                   item.opcode == OP_IMUL3);
      wp       <= (item.opcode == OP_MUL) || (item.opcode == OP_IMUL1);
      dflag    <= 1'b0;
      mcand    <= ld_mc;
      mplier   <= ld_mp;
      neg_prod <= (item.opcode == OP_IMUL1) && (item.acc_low[31] ^ item.dest_value[31]);
      negate_q <= nneg ^ dneg;
      negate_r <= nneg;
      dvsr     <= da_abs;
      // Quotient overflow when high half of |n| is not below |d|.
      derr     <= is_div && ((item.dest_value == 0) || (acc_abs_hi >= da_abs));
      if (is_div) begin
        acc_hi <= acc_abs_hi; acc_lo <= acc_abs_lo;
      end else begin
        acc_hi <= '0; acc_lo <= '0;
      end
    end else if (ctl.mul_step) begin
      // Shift-add: product accumulates into acc_hi, shifts into acc_lo.
      {acc_hi, acc_lo} <= {madd, acc_lo[31:1]};
      mplier <= {1'b0, mplier[31:1]};
    end else if (ctl.div_step) begin
      if (!trial[32]) {acc_hi, acc_lo} <= {trial[31:0], acc_lo[30:0], 1'b1};
      else            {acc_hi, acc_lo} <= {acc_hi[30:0], acc_lo, 1'b0};
    end else if (ctl.fix) begin
      if (is_mul_op(op)) begin
        if (neg_prod) begin
          rres <= rem_pair[31:0]; rhigh <= rem_pair[63:32];
        end else begin
          rres <= acc_lo; rhigh <= acc_hi;
        end
        if (op == OP_IMUL2 || op == OP_IMUL3) rhigh <= '0;
      end else begin
        // acc_lo holds quotient, acc_hi remainder.
        if (derr || (negate_q ? (acc_lo > 32'h8000_0000) :
                     ((op == OP_IDIV) && acc_lo[31]))) begin
          dflag <= 1'b1; wp <= 1'b0; rres <= '0; rhigh <= '0;
        end else begin
          wp    <= 1'b1;
          rres  <= negate_q ? (32'd0 - acc_lo) : acc_lo;
          rhigh <= negate_r ? (32'd0 - acc_hi) : acc_hi;
        end
      end
    end
  end

  assign res = '{result: rres, result_high: rhigh, write_dest: wd, write_acc_pair: wp,
                 carry_out: cf, overflow_out: of, zero_out: zf, sign_out: sf,
                 divide_error: dflag};
endmodule
`default_nettype wire

[sv/xalu_seq.sv]
// Sequencer that steps the shared multiply/divide datapath.
`default_nettype none
module xalu_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_fire,
  input  wire logic           out_fire,
  input  wire logic           is_mul,
  input  wire logic           is_div,
  output xalu_pkg::ctl_t      ctl,
  output logic                busy_idle,
  output logic                done
);
  import xalu_pkg::*;

  state_t     state, state_next;
  logic [4:0] count;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) state_next = is_mul ? ST_MUL : (is_div ? ST_DIV : ST_DONE);
      ST_MUL:  if (count == 5'd31) state_next = ST_FIX;
      ST_DIV:  if (count == 5'd31) state_next = ST_FIX;
      ST_FIX:  state_next = ST_DONE;
      ST_DONE: if (out_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '0;
    ctl.load  = (state == ST_IDLE) && in_fire;
    ctl.mul_step = (state == ST_MUL);
    ctl.div_step = (state == ST_DIV);
    ctl.fix   = (state == ST_FIX);
    busy_idle = (state == ST_IDLE);
    done      = (state == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_MUL || state == ST_DIV) count <= count + 5'd1;
      else count <= '0;
    end
  end
endmodule
`default_nettype wire

[sv/x86_integer_alu_with_flags_unit.sv]
// Top level of the x86 integer ALU with flags.
`default_nettype none
// Add/sub/cmp/inc/dec/neg/adc/sbb and the unused opcodes present their result the
// cycle after acceptance. mul, imul and div, idiv run 32 steps of one shared shift-add /
// restoring-divide unit plus a sign fix step, and present their result after the fix
// step. One transaction is in flight at a time: in_ready is high only while idle, and
// the result register holds until taken.
module x86_integer_alu_with_flags_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire xalu_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output xalu_pkg::out_item_t      out_data
);
  import xalu_pkg::*;

  ctl_t     ctl;
  in_item_t item;
  logic     is_mul, is_div, idle, done;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item <= in_data;
  end

  xalu_seq u_seq (
    .clk, .rst, .in_fire(in_valid && in_ready), .out_fire(out_valid && out_ready),
    .is_mul, .is_div, .ctl, .busy_idle(idle), .done
  );

  // Datapath sees the live input during load, the held copy afterwards.
  in_item_t dp_item;
  assign dp_item = ctl.load ? in_data : item;

  xalu_datapath u_dp (
    .clk, .rst, .ctl, .item(dp_item), .res(out_data), .is_mul, .is_div
  );

  assign in_ready  = idle;
  assign out_valid = done;
endmodule
`default_nettype wire

[sv/xalu_checker.sv]
// Port-level checker for the integer ALU, bound to the top level.
`default_nettype none
`include "x86_integer_alu_with_flags_unit_defines.svh"
module xalu_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire xalu_pkg::out_item_t out_data
);
  `XALU_ASSERT_NOW(a_one_inflight, clk, rst, out_valid, !in_ready, "ready while result pending")
  `XALU_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready, "ready after accept")
  `XALU_ASSERT_NOW(a_err_nowrite, clk, rst, out_valid && out_data.divide_error,
    !out_data.write_acc_pair && !out_data.write_dest, "write on divide error")
  `XALU_ASSERT_NOW(a_one_write, clk, rst, out_valid,
    !(out_data.write_acc_pair && out_data.write_dest), "two write targets")
  `XALU_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
endmodule
bind x86_integer_alu_with_flags_unit xalu_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire

[dv/tb_x86_integer_alu_with_flags_unit.sv]
// Self-checking testbench for the x86 integer ALU with flags.
module tb_x86_integer_alu_with_flags_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import xalu_pkg::*;

  localparam int RANDOM_COUNT = 950;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  always #4 clk = ~clk;

  x86_integer_alu_with_flags_unit u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor flag copy
  logic cf_q, of_q, zf_q, sf_q;
  out_item_t pending_results[$];
  int mismatches = 0;
  int accepted = 0;
  int retired = 0;
  int div_faults = 0;
  int idle_stall_pct = 29;
  int watchdog = 0;

  function automatic int width_bits(logic [1:0] code);
    if (code == W8) return 8;
    if (code == W16) return 16;
    return 32;
  endfunction

  // Compute the ALU outcome and advance the predicted flags.
  function automatic out_item_t alu_outcome(in_item_t it);
    out_item_t o;
    int bits;
    logic [31:0] m, top, d, s, r, sx;
    logic [32:0] full;
    logic [33:0] sub;
    logic [63:0] p, n, na, q, rm;
    logic [31:0] da;
    logic nneg, dneg, qneg, cf, of, arith;
    bits = width_bits(it.op_width);
    m = (bits == 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1);
    top = 32'd1 << (bits - 1);
    d = it.dest_value & m;
    s = it.src_value & m;
    r = '0;
    cf = cf_q;
    of = of_q;
    arith = 1'b1;
    o = '0;
    case (it.opcode)
      OP_ADD, OP_ADC: begin
        full = {1'b0, d} + {1'b0, s} + ((it.opcode == OP_ADC) ? cf_q : 1'b0);
        r = full[31:0] & m;
        cf = (bits == 32) ? full[32] : full[bits];
        of = |((~(d ^ s) & (d ^ r)) & top);
        o.write_dest = 1'b1;
      end
      OP_SUB, OP_CMP, OP_SBB: begin
        sub = {2'b0, s} + ((it.opcode == OP_SBB) ? cf_q : 1'b0);
        r = (d - sub[31:0]) & m;
        cf = {2'b0, d} < sub;
        of = |(((d ^ s) & (d ^ r)) & top);
        o.write_dest = (it.opcode != OP_CMP);
      end
      OP_INC: begin
        r = (d + 1) & m;
        of = (r == top);
        o.write_dest = 1'b1;
      end
      OP_DEC: begin
        r = (d - 1) & m;
        of = (d == top);
        o.write_dest = 1'b1;
      end
      OP_NEG: begin
        r = (0 - d) & m;
        cf = (d != 0);
        of = (d == top);
        o.write_dest = 1'b1;
      end
      default: arith = 1'b0;
    endcase
    if (arith) begin
      o.result = r;
      cf_q = cf;
      of_q = of;
      zf_q = (r == 0);
      sf_q = |(r & top);
    end else begin
      case (it.opcode)
        OP_MUL: begin
          p = {32'b0, it.acc_low} * {32'b0, it.dest_value};
          {o.result_high, o.result} = p;
          o.write_acc_pair = 1'b1;
        end
        OP_IMUL1: begin
          p = {{32{it.acc_low[31]}}, it.acc_low} * {{32{it.dest_value[31]}}, it.dest_value};
          {o.result_high, o.result} = p;
          o.write_acc_pair = 1'b1;
        end
        OP_IMUL2: begin
          o.result = it.dest_value * it.src_value;
          o.write_dest = 1'b1;
        end
        OP_IMUL3: begin
          bits = width_bits(it.imm_width);
          if (bits == 8) sx = {{24{it.src_value[7]}}, it.src_value[7:0]};
          else if (bits == 16) sx = {{16{it.src_value[15]}}, it.src_value[15:0]};
          else sx = it.src_value;
          o.result = it.dest_value * sx;
          o.write_dest = 1'b1;
        end
        OP_DIV: begin
          n = {it.acc_high, it.acc_low};
          if (it.dest_value == 0 || (n / it.dest_value) > 64'hFFFF_FFFF) begin
            o.divide_error = 1'b1;
          end else begin
            q = n / it.dest_value;
            rm = n % it.dest_value;
            o.result = q[31:0];
            o.result_high = rm[31:0];
            o.write_acc_pair = 1'b1;
          end
        end
        OP_IDIV: begin
          n = {it.acc_high, it.acc_low};
          nneg = it.acc_high[31];
          dneg = it.dest_value[31];
          na = nneg ? (64'd0 - n) : n;
          da = dneg ? (32'd0 - it.dest_value) : it.dest_value;
          if (it.dest_value == 0) begin
            o.divide_error = 1'b1;
          end else begin
            q = na / da;
            rm = na % da;
            qneg = nneg ^ dneg;
            if (q > (qneg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
              o.divide_error = 1'b1;
            end else begin
              o.result = qneg ? (32'd0 - q[31:0]) : q[31:0];
              o.result_high = nneg ? (32'd0 - rm[31:0]) : rm[31:0];
              o.write_acc_pair = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    o.carry_out = cf_q;
    o.overflow_out = of_q;
    o.zero_out = zf_q;
    o.sign_out = sf_q;
    return o;
  endfunction

  // Directed rows; typed_expect marks rows whose outcome is written in by hand.
  typedef struct {
    in_item_t item;
    logic typed_expect;
    out_item_t outcome;
  } directed_row_t;

  function automatic in_item_t mk(logic [3:0] op, logic [1:0] w, logic [1:0] iw,
                                  logic [31:0] d, logic [31:0] s,
                                  logic [31:0] lo, logic [31:0] hi);
    in_item_t it;
    it.opcode = op;
    it.op_width = w;
    it.imm_width = iw;
    it.dest_value = d;
    it.src_value = s;
    it.acc_low = lo;
    it.acc_high = hi;
    return it;
  endfunction

  directed_row_t directed_rows[$];

  function automatic out_item_t flags_only(logic c, logic o, logic z, logic s, logic e);
    out_item_t r;
    r = '0;
    r.carry_out = c;
    r.overflow_out = o;
    r.zero_out = z;
    r.sign_out = s;
    r.divide_error = e;
    return r;
  endfunction

  task automatic add_row(in_item_t it, logic typed, out_item_t res);
    directed_row_t row;
    row.item = it;
    row.typed_expect = typed;
    row.outcome = res;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed_rows();
    out_item_t e;
    // div by zero straight after reset: flags still clear
    add_row(mk(OP_DIV, 2'd2, 2'd2, 32'd0, 32'd0, 32'd5, 32'd0), 1'b1,
            flags_only(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    // 8-bit 0xFF + 1 wraps to zero with carry
    e = flags_only(1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    e.write_dest = 1'b1;
    add_row(mk(OP_ADD, W8, W8, 32'hFFFF_FFFF, 32'h1, '0, '0), 1'b1, e);
    // unused opcode keeps flags
    add_row(mk(4'd14, 2'd2, 2'd2, 32'h1, 32'h2, 32'h3, 32'h4), 1'b1,
            flags_only(1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
    add_row(mk(OP_ADC, W8, W8, 32'h7F, 32'h0, '0, '0), 1'b0, '0);
    add_row(mk(OP_ADD, 2'd3, 2'd3, 32'h7FFF_FFFF, 32'h1, '0, '0), 1'b0, '0);
    add_row(mk(OP_SUB, W16, W8, 32'h0, 32'hFFFF, '0, '0), 1'b0, '0);
    add_row(mk(OP_SBB, W16, W8, 32'h8000, 32'hFFFF, '0, '0), 1'b0, '0);
    add_row(mk(OP_CMP, 2'd2, W8, 32'h8000_0000, 32'h1, '0, '0), 1'b0, '0);
    add_row(mk(OP_INC, W8, W8, 32'hFFFF_FF7F, '0, '0, '0), 1'b0, '0);
    add_row(mk(OP_DEC, W16, W8, 32'h8000, '0, '0, '0), 1'b0, '0);
    add_row(mk(OP_NEG, 2'd2, W8, 32'h8000_0000, '0, '0, '0), 1'b0, '0);
    add_row(mk(OP_NEG, W8, W8, 32'h100, '0, '0, '0), 1'b0, '0);
    add_row(mk(OP_ADC, 2'd2, W8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0), 1'b0, '0);
    add_row(mk(OP_SBB, 2'd2, W8, 32'h0, 32'hFFFF_FFFF, '0, '0), 1'b0, '0);
    add_row(mk(OP_MUL, 2'd2, W8, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, '0), 1'b0, '0);
    add_row(mk(OP_IMUL1, 2'd2, W8, 32'h8000_0000, '0, 32'h8000_0000, '0), 1'b0, '0);
    add_row(mk(OP_IMUL2, 2'd2, W8, 32'hFFFF_FFFF, 32'h7FFF_FFFF, '0, '0), 1'b0, '0);
    add_row(mk(OP_IMUL3, 2'd2, W8, 32'h3, 32'h80, '0, '0), 1'b0, '0);
    add_row(mk(OP_IMUL3, 2'd2, W16, 32'h3, 32'h8000, '0, '0), 1'b0, '0);
    add_row(mk(OP_IMUL3, 2'd2, 2'd3, 32'h3, 32'h8000_0000, '0, '0), 1'b0, '0);
    add_row(mk(OP_DIV, 2'd2, W8, 32'h1, '0, '0, 32'h1), 1'b0, '0);
    add_row(mk(OP_DIV, 2'd2, W8, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFE, 32'hFFFF_FFFE), 1'b0, '0);
    add_row(mk(OP_IDIV, 2'd2, W8, 32'hFFFF_FFFF, '0, 32'h8000_0000, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(mk(OP_IDIV, 2'd2, W8, 32'hFFFF_FFFF, '0, 32'h7FFF_FFFF, 32'h0), 1'b0, '0);
    add_row(mk(OP_IDIV, 2'd2, W8, 32'h0, '0, 32'h1, 32'h0), 1'b0, '0);
    add_row(mk(OP_IDIV, 2'd2, W8, 32'h7, '0, 32'hFFFF_FFF9, 32'hFFFF_FFFF), 1'b0, '0);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000 ^ $urandom_range(0, 3);
      3: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.opcode = ($urandom_range(0, 39) == 0) ? 4'($urandom_range(14, 15))
                                             : 4'($urandom_range(0, 13));
    it.op_width = 2'($urandom_range(0, 3));
    it.imm_width = 2'($urandom_range(0, 3));
    it.dest_value = rand_word();
    it.src_value = rand_word();
    it.acc_low = rand_word();
    it.acc_high = rand_word();
    // bias divides toward dividends that fit, so quotients are produced
    if ((it.opcode == OP_DIV || it.opcode == OP_IDIV) && $urandom_range(0, 2) != 0) begin
      it.acc_high = $urandom_range(0, 1) ? 32'h0 : {32{it.acc_low[31]}};
      if (it.dest_value == 0) it.dest_value = $urandom_range(1, 1000);
    end
    return it;
  endfunction

  // Send one transaction and record its expected outcome.
  task automatic send_item(in_item_t it, logic typed, out_item_t hand);
    out_item_t e;
    if (idle_stall_pct != 0 && $urandom_range(0, 99) < idle_stall_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (idle_stall_pct != 0 && $urandom_range(0, 99) < idle_stall_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e = alu_outcome(it);
    if (typed && e != hand) begin
      $display("%0t directed row disagrees with predictor: exp %p got %p", $time, hand, e);
      mismatches++;
    end
    if (e.divide_error) div_faults++;
    pending_results.push_back(typed ? hand : e);
    accepted++;
  endtask

  // Retire results and compare each field.
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && out_ready) begin
      watchdog <= 0;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: exp none got %p", $time, out_data);
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        retired++;
        if (out_data.result !== e.result)
          $display("%0t result: exp %h got %h", $time, e.result, out_data.result);
        if (out_data.result_high !== e.result_high)
          $display("%0t result_high: exp %h got %h", $time, e.result_high,
                   out_data.result_high);
        if (out_data.write_dest !== e.write_dest)
          $display("%0t write_dest: exp %b got %b", $time, e.write_dest, out_data.write_dest);
        if (out_data.write_acc_pair !== e.write_acc_pair)
          $display("%0t write_acc_pair: exp %b got %b", $time, e.write_acc_pair,
                   out_data.write_acc_pair);
        if (out_data.carry_out !== e.carry_out)
          $display("%0t carry_out: exp %b got %b", $time, e.carry_out, out_data.carry_out);
        if (out_data.overflow_out !== e.overflow_out)
          $display("%0t overflow_out: exp %b got %b", $time, e.overflow_out,
                   out_data.overflow_out);
        if (out_data.zero_out !== e.zero_out)
          $display("%0t zero_out: exp %b got %b", $time, e.zero_out, out_data.zero_out);
        if (out_data.sign_out !== e.sign_out)
          $display("%0t sign_out: exp %b got %b", $time, e.sign_out, out_data.sign_out);
        if (out_data.divide_error !== e.divide_error)
          $display("%0t divide_error: exp %b got %b", $time, e.divide_error,
                   out_data.divide_error);
        if (out_data !== e) mismatches++;
      end
    end else if (!rst && in_valid && in_ready) begin
      watchdog <= 0;
    end else if (!rst) begin
      watchdog <= watchdog + 1;
    end
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", watchdog);
      $display("x86_integer_alu_with_flags_unit verification failed");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= (idle_stall_pct == 0) || ($urandom_range(0, 99) >= idle_stall_pct);
  end

  initial begin
    cf_q = 1'b0;
    of_q = 1'b0;
    zf_q = 1'b0;
    sf_q = 1'b0;
    build_directed_rows();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed_expect,
                directed_rows[i].outcome);
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      // stretch with no idling on either side
      if (i == 300) idle_stall_pct = 0;
      if (i == 450) idle_stall_pct = 29;
      // hold off until every outstanding result is back
      if (i == 600) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_item(rand_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d instructions (%0d directed), %0d results checked, %0d divide faults.",
             accepted, directed_rows.size(), retired, div_faults);
    if (mismatches == 0) begin
      $display("x86_integer_alu_with_flags_unit verification clean");
    end else begin
      $display("x86_integer_alu_with_flags_unit verification failed");
    end
    $finish;
  end
endmodule
